FILE: hdl/quadrature_speed_estimator_unit_assert.svh
// ----------------------------------------------------------------------------
// quadrature speed estimator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_SPEED_ESTIMATOR_UNIT_ASSERT_SVH
`define QUADRATURE_SPEED_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define QSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// shared types, widths, register codes and the x4 decode table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qse_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int DELTA_BITS     = 16;
	localparam int SPEED_BITS     = 40;
	localparam int SCALE_BITS     = 24;
	localparam int WEIGHT_BITS    = 17;
	localparam int FRAC_BITS      = 16;
	localparam int MUL_B_BITS     = WEIGHT_BITS + 1;
	localparam int PROD_BITS      = SPEED_BITS + MUL_B_BITS;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = SCALE_BITS;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE        = 17'd65536;
	localparam logic [SCALE_BITS-1:0]  SPEED_SCALE_RESET = 24'd12452;
	localparam logic [WEIGHT_BITS-1:0] EMA_WEIGHT_RESET  = 17'd45875;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_SCALE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EMA_WEIGHT  = 1'd1;

	// indexed by {previous pin pair, current pin pair}, pair = {a, b}
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		 2'sd0, -2'sd1,  2'sd1,  2'sd0,
		 2'sd1,  2'sd0,  2'sd0, -2'sd1,
		-2'sd1,  2'sd0,  2'sd0,  2'sd1,
		 2'sd0,  2'sd1, -2'sd1,  2'sd0
	};

	localparam logic OP_PIN_EVENT   = 1'b0;
	localparam logic OP_PERIOD_TICK = 1'b1;

	typedef struct packed {
		logic operation;
		logic pin_a;
		logic pin_b;
	} qse_in_t;

	typedef struct packed {
		logic signed [DELTA_BITS-1:0] tick_delta;
		logic signed [SPEED_BITS-1:0] speed_instant;
		logic signed [SPEED_BITS-1:0] speed_filtered;
	} qse_out_t;

endpackage

FILE: hdl/qse_mul.sv
// ----------------------------------------------------------------------------
// qse_mul
// shared signed multiplier used by the scale, weight and blend steps of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qse_mul (
	input  logic signed [qse_pkg::SPEED_BITS-1:0] a,
	input  logic signed [qse_pkg::MUL_B_BITS-1:0] b,
	output logic signed [qse_pkg::PROD_BITS-1:0]  product
);

	logic signed [qse_pkg::PROD_BITS-1:0] a_ext;
	logic signed [qse_pkg::PROD_BITS-1:0] b_ext;

	always_comb begin
		a_ext   = qse_pkg::PROD_BITS'(a);
		b_ext   = qse_pkg::PROD_BITS'(b);
		product = a_ext * b_ext;
	end

endmodule

FILE: hdl/quadrature_speed_estimator_unit.sv
// ----------------------------------------------------------------------------
// quadrature_speed_estimator_unit
// x4 quadrature decoder with a scaled, exponentially averaged speed output
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready / in_item): operation 0 is a pin event
//   that samples channels a and b and moves the position count by -1, 0 or +1;
//   it gives no item out. operation 1 is a period tick that produces one item
//   on the output channel (out_valid / out_ready / out_item).
//   configuration: cfg_wen writes cfg_data into register cfg_index at the
//   clock edge (0 speed_scale, 1 ema_weight); write only while idle.
// sequencing
//   a pin event does not leave the idle state, so in_ready stays high.
//   a period tick runs through the sequencer around one shared multiplier:
//   difference, saturate, scale, weight, blend, write. the first tick skips
//   the weight and blend steps. out_valid rises when the write step ends,
//   which waits while a held result is not taken, and in_ready returns in
//   the same cycle, so a new tick is taken only once the last one is through.
// reset and stall
//   arst_n clears the count, pin history and average and loads the register
//   defaults. a stalled receiver holds the result in the output register;
//   events are still taken, a following tick waits in its write step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quadrature_speed_estimator_unit_assert.svh"

module quadrature_speed_estimator_unit #(
	parameter int COUNT_BITS = qse_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  qse_pkg::qse_in_t                      in_item,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output qse_pkg::qse_out_t                     out_item,
	input  logic                                  cfg_wen,
	input  logic [qse_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [qse_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int DB = qse_pkg::DELTA_BITS;
	localparam int SB = qse_pkg::SPEED_BITS;
	localparam int FB = qse_pkg::FRAC_BITS;
	localparam int PB = qse_pkg::PROD_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SAT,
		S_SCALE,
		S_WEIGHT,
		S_BLEND,
		S_WR
	} state_t;

	state_t state_q;

	// configuration
	logic [qse_pkg::SCALE_BITS-1:0]  scale_q;
	logic [qse_pkg::WEIGHT_BITS-1:0] weight_q;

	// decoder state
	logic [1:0]            pins_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] last_q;

	// averaging state
	logic signed [SB-1:0] avg_q;
	logic                 seeded_q;

	// working registers
	logic [COUNT_BITS-1:0] diff_q;
	logic signed [DB-1:0]  delta_q;
	logic signed [SB-1:0]  inst_q;
	logic signed [PB-1:0]  acc_q;

	// output register
	logic              out_valid_q;
	qse_pkg::qse_out_t out_q;

	// pin decode
	logic [1:0]        pins_new;
	logic signed [1:0] step;
	logic [COUNT_BITS-1:0] pos_next;

	// handshakes
	logic in_take;
	logic out_free;

	// saturation
	logic [COUNT_BITS-DB:0] diff_hi;
	logic signed [DB-1:0]   delta_sat;

	// weights, clamped to one
	logic [qse_pkg::WEIGHT_BITS-1:0] w_eff;
	logic [qse_pkg::WEIGHT_BITS-1:0] w_rest;

	// shared multiplier
	logic signed [SB-1:0]                  mul_a;
	logic signed [qse_pkg::MUL_B_BITS-1:0] mul_b;
	logic signed [PB-1:0]                  mul_p;
	logic signed [PB-1:0]                  blend_sum;

	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		pins_new = {in_item.pin_a, in_item.pin_b};
		step     = qse_pkg::STEP_TABLE[{pins_q, pins_new}];
		if (step == 2'sd1) begin
			pos_next = pos_q + COUNT_BITS'(1);
		end else if (step == -2'sd1) begin
			pos_next = pos_q - COUNT_BITS'(1);
		end else begin
			pos_next = pos_q;
		end
	end

	// clamp the wrapped difference to the signed delta range
	always_comb begin
		diff_hi = diff_q[COUNT_BITS-1:DB-1];
		if ((&diff_hi) || !(|diff_hi)) begin
			delta_sat = diff_q[DB-1:0];
		end else if (diff_q[COUNT_BITS-1]) begin
			delta_sat = {1'b1, {(DB-1){1'b0}}};
		end else begin
			delta_sat = {1'b0, {(DB-1){1'b1}}};
		end
	end

	always_comb begin
		w_eff  = (weight_q > qse_pkg::WEIGHT_ONE) ? qse_pkg::WEIGHT_ONE : weight_q;
		w_rest = qse_pkg::WEIGHT_ONE - w_eff;
	end

	// operand select: scale step, new-sample weight, old-average weight
	always_comb begin
		case (state_q)
			S_SCALE: begin
				mul_a = SB'($signed({1'b0, scale_q}));
				mul_b = qse_pkg::MUL_B_BITS'(delta_q);
			end
			S_WEIGHT: begin
				mul_a = inst_q;
				mul_b = $signed({1'b0, w_eff});
			end
			default: begin
				mul_a = avg_q;
				mul_b = $signed({1'b0, w_rest});
			end
		endcase
	end

	qse_mul u_mul (
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p)
	);

	// the arithmetic shift gives the floor of the weighted sum
	assign blend_sum = acc_q + mul_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scale_q     <= qse_pkg::SPEED_SCALE_RESET;
			weight_q    <= qse_pkg::EMA_WEIGHT_RESET;
			pins_q      <= 2'b00;
			pos_q       <= '0;
			last_q      <= '0;
			avg_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					qse_pkg::REG_SPEED_SCALE: scale_q  <= cfg_data;
					qse_pkg::REG_EMA_WEIGHT:  weight_q <= cfg_data[qse_pkg::WEIGHT_BITS-1:0];
					default: ;
				endcase
			end

			// load a new result, or drop valid once the held one is taken
			if (state_q == S_WR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (in_item.operation == qse_pkg::OP_PERIOD_TICK) begin
							last_q  <= pos_q;
							state_q <= S_SAT;
						end else begin
							pos_q  <= pos_next;
							pins_q <= pins_new;
						end
					end
				end
				S_SAT: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					// first tick only seeds the average
					state_q <= seeded_q ? S_WEIGHT : S_WR;
				end
				S_WEIGHT: begin
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					avg_q   <= blend_sum[FB+SB-1:FB];
					state_q <= S_WR;
				end
				S_WR: begin
					if (!seeded_q) begin
						avg_q    <= inst_q;
						seeded_q <= 1'b1;
					end
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take && in_item.operation == qse_pkg::OP_PERIOD_TICK) begin
			diff_q <= pos_q - last_q;
		end
		if (state_q == S_SAT) begin
			delta_q <= delta_sat;
		end
		if (state_q == S_SCALE) begin
			// 16 x 24 bit product always fits the 40 bit speed range
			inst_q <= mul_p[SB-1:0];
		end
		if (state_q == S_WEIGHT) begin
			acc_q <= mul_p;
		end
		if (state_q == S_WR && out_free) begin
			out_q.tick_delta     <= delta_q;
			out_q.speed_instant  <= inst_q;
			out_q.speed_filtered <= seeded_q ? avg_q : inst_q;
		end
	end

	`QSE_ASSERT_NEXT(a_tick_snapshot, in_take && in_item.operation == qse_pkg::OP_PERIOD_TICK, last_q == $past(pos_q) && state_q == S_SAT, "tick did not capture the position count")

	`QSE_ASSERT_NEXT(a_event_step, in_take && in_item.operation == qse_pkg::OP_PIN_EVENT, (pos_q == $past(pos_q)) || (pos_q == $past(pos_q) + COUNT_BITS'(1)) || (pos_q == $past(pos_q) - COUNT_BITS'(1)), "pin event moved the count by more than one")

	`QSE_ASSERT_NOW(a_result_from_write, $rose(out_valid_q), $past(state_q == S_WR), "result appeared outside the write step")

	`QSE_ASSERT_NOW(a_result_seeded, out_valid_q, seeded_q, "result given before the average was seeded")

endmodule
